// ===== hw/rtl/thick_line_stepper_assert.svh =====
// Assertion macros for the thick line stepper RTL, used by tls_datapath.
// Each macro samples on posedge clk and is disabled while rst is high.
// Expands to nothing when SYNTHESIS is defined.
`ifndef THICK_LINE_STEPPER_ASSERT_SVH
`define THICK_LINE_STEPPER_ASSERT_SVH

`ifndef SYNTHESIS
`define TLS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define TLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TLS_ASSERT_SAME(lbl, ante, cons, msg)
`define TLS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/tls_pkg.sv =====
// Shared types and constants for the thick line stepper.
// No dependencies; imported by every RTL module of the block.
`timescale 1ns / 1ps
package tls_pkg;

  localparam int COORD_BITS    = 12;
  localparam int SIZE_BITS     = COORD_BITS + 1;
  localparam int CNT_BITS      = $clog2(COORD_BITS);
  localparam int CFG_IDX_BITS  = 1;
  localparam int IN_RAW_BITS   = 4 * COORD_BITS;
  localparam int IN_DATA_BITS  = ((IN_RAW_BITS + 7) / 8) * 8;
  localparam int OUT_RAW_BITS  = 6 * COORD_BITS + 2;
  localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

  localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(1 << COORD_BITS);

  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef enum logic [1:0] {
    MODE_VERT = 2'd0,
    MODE_HORZ = 2'd1,
    MODE_XMAJ = 2'd2,
    MODE_YMAJ = 2'd3
  } tls_mode_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } tls_seg_t;

  typedef struct packed {
    coord_t center_x;
    coord_t center_y;
    coord_t side_one_x;
    coord_t side_one_y;
    logic   side_one_valid;
    coord_t side_two_x;
    coord_t side_two_y;
    logic   side_two_valid;
    logic   last;
  } tls_stroke_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic advance;
  } tls_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic needs_div;
    logic stroke;
    logic div_done;
    logic div_active;
  } tls_stat_t;

endpackage

// ===== hw/rtl/tls_divider.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on tls_pkg. Divisor must be nonzero and not above the dividend.
`timescale 1ns / 1ps
module tls_divider import tls_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  coord_t dividend,
  input  coord_t divisor,
  output logic   active,
  output logic   done,
  output coord_t quotient
);

  logic [COORD_BITS:0]   rem;
  coord_t                quo;
  coord_t                dvs;
  logic [CNT_BITS-1:0]   cnt;
  logic [COORD_BITS:0]   shifted;
  logic [COORD_BITS+1:0] diff;

  always_comb begin
    shifted = {rem[COORD_BITS-1:0], quo[COORD_BITS-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
        rem    <= '0;
        quo    <= dividend;
        dvs    <= divisor;
      end else if (active) begin
        // borrow set: keep the shifted remainder, quotient bit 0
        rem <= diff[COORD_BITS+1] ? shifted : diff[COORD_BITS:0];
        quo <= {quo[COORD_BITS-2:0], ~diff[COORD_BITS+1]};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_BITS'(COORD_BITS - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

// ===== hw/rtl/tls_datapath.sv =====
// Segment state, stroke generation, image clipping and output word register.
// Depends on tls_pkg, tls_divider and the assertion macro header.
`timescale 1ns / 1ps
`include "thick_line_stepper_assert.svh"
module tls_datapath import tls_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  tls_cmd_t                cmd,
  input  tls_seg_t                seg,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [SIZE_BITS-1:0]    cfg_data,
  output tls_stat_t               stat,
  output tls_stroke_t             stroke
);

  logic [SIZE_BITS-1:0] image_width;
  logic [SIZE_BITS-1:0] image_height;

  coord_t    cursor_x, cursor_y, goal_x, goal_y;
  logic      step_neg_x, step_neg_y;
  tls_mode_t line_mode;
  coord_t    run_length, run_count;
  logic      busy;

  // load decode
  coord_t    ax, ay, major, minor;
  tls_mode_t mode_load;

  // step decode
  coord_t      nx, ny, cursor_x_next, cursor_y_next;
  logic        run_wrap, minor_move;
  logic        x_up_ok, x_dn_ok, y_up_ok, y_dn_ok;
  tls_stroke_t st;

  logic   div_active, div_done;
  coord_t quotient;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= SIZE_RESET;
      image_height <= SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data;
        CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    ax = (seg.end_x >= seg.start_x) ? seg.end_x - seg.start_x : seg.start_x - seg.end_x;
    ay = (seg.end_y >= seg.start_y) ? seg.end_y - seg.start_y : seg.start_y - seg.end_y;
    if (ax == '0)      mode_load = MODE_VERT;
    else if (ay == '0) mode_load = MODE_HORZ;
    else if (ax >= ay) mode_load = MODE_XMAJ;
    else               mode_load = MODE_YMAJ;
    major = (ax >= ay) ? ax : ay;
    minor = (ax >= ay) ? ay : ax;
  end

  tls_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.load && mode_load[1]),
    .dividend (major),
    .divisor  (minor),
    .active   (div_active),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    nx = step_neg_x ? cursor_x - 1'b1 : cursor_x + 1'b1;
    ny = step_neg_y ? cursor_y - 1'b1 : cursor_y + 1'b1;
    run_wrap   = run_count >= run_length;
    minor_move = line_mode[1] && run_wrap &&
                 ((line_mode == MODE_XMAJ) ? (cursor_y != goal_y) : (cursor_x != goal_x));

    x_up_ok = (cursor_x != '1) && (({1'b0, cursor_x} + 1'b1) < image_width);
    y_up_ok = (cursor_y != '1) && (({1'b0, cursor_y} + 1'b1) < image_height);
    x_dn_ok = cursor_x != '0;
    y_dn_ok = cursor_y != '0;

    st = '0;
    st.center_x   = cursor_x;
    st.center_y   = cursor_y;
    cursor_x_next = cursor_x;
    cursor_y_next = cursor_y;
    unique case (line_mode)
      MODE_VERT: begin
        st.side_one_x = cursor_x + 1'b1; st.side_one_y = cursor_y; st.side_one_valid = x_up_ok;
        st.side_two_x = cursor_x - 1'b1; st.side_two_y = cursor_y; st.side_two_valid = x_dn_ok;
        cursor_y_next = ny;
        st.last       = ny == goal_y;
      end
      MODE_HORZ: begin
        st.side_one_x = cursor_x; st.side_one_y = cursor_y + 1'b1; st.side_one_valid = y_up_ok;
        st.side_two_x = cursor_x; st.side_two_y = cursor_y - 1'b1; st.side_two_valid = y_dn_ok;
        cursor_x_next = nx;
        st.last       = nx == goal_x;
      end
      MODE_XMAJ: begin
        // neighbors sit at the column already stepped to
        st.side_one_x = nx; st.side_one_y = cursor_y - 1'b1; st.side_one_valid = y_dn_ok;
        st.side_two_x = nx; st.side_two_y = cursor_y + 1'b1; st.side_two_valid = y_up_ok;
        cursor_x_next = nx;
        st.last       = nx == goal_x;
      end
      MODE_YMAJ: begin
        st.side_one_x = cursor_x + 1'b1; st.side_one_y = ny; st.side_one_valid = x_up_ok;
        st.side_two_x = cursor_x - 1'b1; st.side_two_y = ny; st.side_two_valid = x_dn_ok;
        cursor_y_next = ny;
        st.last       = ny == goal_y;
      end
      default: ;
    endcase

    // clipped neighbors report zero coordinates
    if (!st.side_one_valid) begin
      st.side_one_x = '0;
      st.side_one_y = '0;
    end
    if (!st.side_two_valid) begin
      st.side_two_x = '0;
      st.side_two_y = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x   <= '0;
      cursor_y   <= '0;
      goal_x     <= '0;
      goal_y     <= '0;
      step_neg_x <= 1'b0;
      step_neg_y <= 1'b0;
      line_mode  <= MODE_VERT;
      run_length <= '0;
      run_count  <= '0;
      busy       <= 1'b0;
    end else begin
      if (cmd.load) begin
        cursor_x   <= seg.start_x;
        cursor_y   <= seg.start_y;
        goal_x     <= seg.end_x;
        goal_y     <= seg.end_y;
        step_neg_x <= seg.end_x < seg.start_x;
        step_neg_y <= seg.end_y < seg.start_y;
        line_mode  <= mode_load;
        run_length <= '0;
        run_count  <= '0;
        busy       <= (ax != '0) || (ay != '0);
      end else if (cmd.advance && busy) begin
        if (minor_move) begin
          run_count <= '0;
          if (line_mode == MODE_XMAJ) cursor_y <= ny;
          else                        cursor_x <= nx;
        end else begin
          if (line_mode[1]) run_count <= (run_wrap ? '0 : run_count) + 1'b1;
          cursor_x <= cursor_x_next;
          cursor_y <= cursor_y_next;
          if (st.last) busy <= 1'b0;
        end
      end
      if (div_done) run_length <= quotient;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.advance && stat.stroke) stroke <= st;
  end

  always_comb begin
    stat.needs_div  = mode_load[1];
    stat.stroke     = busy && !minor_move;
    stat.div_done   = div_done;
    stat.div_active = div_active;
  end

  `TLS_ASSERT_NEXT(a_idle_advance_quiet, cmd.advance && !busy, !busy && $stable(cursor_x) && $stable(cursor_y), "advance while idle changed the cursor")
  `TLS_ASSERT_NEXT(a_last_ends_segment, cmd.advance && stat.stroke && st.last, !busy, "last stroke left the segment busy")
  `TLS_ASSERT_SAME(a_run_length_set, busy && line_mode[1] && !div_active && !div_done, run_length != '0, "diagonal segment has zero run length")

endmodule

// ===== hw/rtl/tls_ctrl.sv =====
// Controller: input acceptance, divide wait and output word valid.
// Depends on tls_pkg; drives tls_datapath through command/status structs.
`timescale 1ns / 1ps
module tls_ctrl import tls_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_op,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  tls_stat_t stat,
  output tls_cmd_t  cmd
);

  typedef enum logic {
    S_IDLE,
    S_DIVIDE
  } state_t;

  state_t state;
  logic   accept;

  assign in_ready    = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept      = in_valid && in_ready;
  assign cmd.load    = accept && (in_op == OP_LOAD);
  assign cmd.advance = accept && (in_op == OP_ADVANCE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.advance && stat.stroke) out_valid <= 1'b1;
      else if (out_ready)             out_valid <= 1'b0;
      unique case (state)
        S_IDLE:   if (cmd.load && stat.needs_div) state <= S_DIVIDE;
        S_DIVIDE: if (stat.div_done)              state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/thick_line_stepper.sv =====
// Thick line stepper: run-ratio rasterizer, at most one stroke per advance word.
// Advance: stroke word on m_tvalid in the cycle after accept; one word per cycle
// while m_tready is high. Load: x-major/y-major loads run a divide (one quotient
// bit per cycle) and latch the quotient as run length; no word is taken until
// the divide is done.
// Reset (rst, synchronous, active high): idle, image 4096 x 4096, no word out.
`timescale 1ns / 1ps
module thick_line_stepper import tls_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  // slave side
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [IN_DATA_BITS-1:0]  s_tdata,   // start_x, start_y, end_x, end_y
  input  logic                     s_tuser,   // operation (0 load, 1 advance)
  // master side
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_DATA_BITS-1:0] m_tdata,   // center_x, center_y, side_one_x,
                                              // side_one_y, side_one_valid, side_two_x,
                                              // side_two_y, side_two_valid, zero pad
  output logic                     m_tlast,   // last stroke of the segment
  // configuration
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index, // 0 image_width, 1 image_height
  input  logic [SIZE_BITS-1:0]     cfg_data
);

  tls_cmd_t    cmd;
  tls_stat_t   stat;
  tls_seg_t    seg;
  tls_stroke_t stroke;
  logic [OUT_RAW_BITS-1:0] out_raw;

  // unpack the input word, first field in the low bits
  assign seg.start_x = s_tdata[0*COORD_BITS +: COORD_BITS];
  assign seg.start_y = s_tdata[1*COORD_BITS +: COORD_BITS];
  assign seg.end_x   = s_tdata[2*COORD_BITS +: COORD_BITS];
  assign seg.end_y   = s_tdata[3*COORD_BITS +: COORD_BITS];

  tls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_op     (s_tuser),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // stroke register in the datapath is the output stage; it only loads
  // when the controller has room, so a stalled word holds
  tls_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .seg       (seg),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .stroke    (stroke)
  );

  // pack the output word, first field in the low bits
  assign out_raw = {stroke.side_two_valid, stroke.side_two_y, stroke.side_two_x,
                    stroke.side_one_valid, stroke.side_one_y, stroke.side_one_x,
                    stroke.center_y, stroke.center_x};
  assign m_tdata = OUT_DATA_BITS'(out_raw);
  assign m_tlast = stroke.last;

endmodule
